>>> hdl/llo_pkg.sv
// ----------------------------------------------------------------------------
// llo_pkg
// Shared constants and types for the longest line of ones block.
// ----------------------------------------------------------------------------
package llo_pkg;

   localparam int DEF_MAX_COLUMNS = 1024;
   localparam int DEF_MAX_RUN     = 1024;

   localparam int ROW_WIDTH_W = 11;
   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd1024;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // Register index, taken from the word address bit of the CSR port.
   localparam logic REG_ROW_WIDTH = 1'b0;

   // Position of a cell in the matrix, carried from the input stage to the
   // run computation.
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic last_col;
      logic final_cell;
   } cell_flags_type;

endpackage

>>> hdl/llo_line_buf.sv
// ----------------------------------------------------------------------------
// llo_line_buf
// One row of run lengths indexed by column, with a registered read port and
// a write port. A read at the address being written returns the new data.
// ----------------------------------------------------------------------------
module llo_line_buf #(
   parameter int DEPTH  = llo_pkg::DEF_MAX_COLUMNS,
   parameter int DATA_W = 11,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         // The previous cell may write the entry that this cell reads.
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/llo_runs.sv
// ----------------------------------------------------------------------------
// llo_runs
// Run length update for one cell in all four directions, and the running
// maximum over the matrix.
// ----------------------------------------------------------------------------
module llo_runs #(
   parameter int MAX_RUN = llo_pkg::DEF_MAX_RUN,
   parameter int RUN_W   = $clog2(MAX_RUN + 1)
) (
   input  logic                    cell_set,
   input  llo_pkg::cell_flags_type flags,
   input  logic [RUN_W-1:0]        horiz_prev,
   input  logic [RUN_W-1:0]        vert_above,
   input  logic [RUN_W-1:0]        diag_upper_left,
   input  logic [RUN_W-1:0]        anti_upper_right,
   input  logic [RUN_W-1:0]        best_prev,
   output logic [RUN_W-1:0]        horiz_run,
   output logic [RUN_W-1:0]        vert_run,
   output logic [RUN_W-1:0]        diag_run,
   output logic [RUN_W-1:0]        anti_run,
   output logic [RUN_W-1:0]        best_next
);

   localparam logic [RUN_W-1:0] RUN_ONE = RUN_W'(1);
   localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_RUN);

   function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] run);
      return (run >= RUN_MAX) ? RUN_MAX : run + RUN_ONE;
   endfunction

   logic [RUN_W-1:0] max_hv;
   logic [RUN_W-1:0] max_da;
   logic [RUN_W-1:0] max_cell;

   always_comb begin
      if (cell_set) begin
         horiz_run = flags.first_col ? RUN_ONE : bump(horiz_prev);
         vert_run  = flags.first_row ? RUN_ONE : bump(vert_above);
         diag_run  = (flags.first_row || flags.first_col) ? RUN_ONE
                                                           : bump(diag_upper_left);
         anti_run  = (flags.first_row || flags.last_col) ? RUN_ONE
                                                          : bump(anti_upper_right);
      end else begin
         horiz_run = '0;
         vert_run  = '0;
         diag_run  = '0;
         anti_run  = '0;
      end
   end

   assign max_hv    = (horiz_run > vert_run) ? horiz_run : vert_run;
   assign max_da    = (diag_run > anti_run) ? diag_run : anti_run;
   assign max_cell  = (max_hv > max_da) ? max_hv : max_da;
   assign best_next = (max_cell > best_prev) ? max_cell : best_prev;

endmodule

>>> hdl/longest_line_of_ones_four_dir.sv
// ----------------------------------------------------------------------------
// longest_line_of_ones_four_dir
// Longest straight line of set cells in a binary matrix streamed in raster
// order, over horizontal, vertical, diagonal and anti-diagonal directions.
// ----------------------------------------------------------------------------
//
//   channel | direction | beat carries                  | handshake
//   --------+-----------+-------------------------------+----------------------
//   req     | in        | cell_set, final_cell          | req_valid / req_stall
//   rsp     | out       | longest_run (on final cell)   | rsp_valid / rsp_stall
//   csr     | in/out    | row_width at word 0           | APB, pready tied high
//
// One cell is taken every cycle while the input is not stalled. The three
// line buffers are read at the edge that takes a cell; its runs are computed
// in the next cycle and written back at the edge that moves the cell out of
// the run stage, which also loads the result for a final cell. The input
// stalls only while a final cell in the run stage meets a stalled earlier
// result. Reset is synchronous and clears the matrix position and running
// counts; the line buffers need no clearing.
// ----------------------------------------------------------------------------
module longest_line_of_ones_four_dir #(
   parameter int MAX_COLUMNS = llo_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_RUN     = llo_pkg::DEF_MAX_RUN,
   parameter int RUN_W       = $clog2(MAX_RUN + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cell_set,
   input  logic                           req_final_cell,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [RUN_W-1:0]               rsp_longest_run,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [llo_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [llo_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [llo_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int WID_W = COL_W + 1;

   // Configuration.
   logic [llo_pkg::ROW_WIDTH_W-1:0] row_width_ff, row_width_in;
   logic                            csr_write;

   // Input stage.
   logic             accept;
   logic [COL_W-1:0] col_ff, col_in;
   logic             first_row_ff, first_row_in;
   logic [WID_W-1:0] eff_width;
   logic             last_col;
   logic [COL_W-1:0] anti_addr;

   // Run stage.
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_cell_set_ff;
   llo_pkg::cell_flags_type s1_flags_ff;
   logic [COL_W-1:0]        s1_col_ff;
   logic                    s1_advance;
   logic [RUN_W-1:0]        horiz_ff, horiz_in;
   logic [RUN_W-1:0]        held_ul_ff, held_ul_in;
   logic [RUN_W-1:0]        best_ff, best_in;
   logic [RUN_W-1:0]        vert_rd, diag_rd, anti_rd;
   logic [RUN_W-1:0]        horiz_run, vert_run, diag_run, anti_run, best_next;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RUN_W-1:0] rsp_run_ff, rsp_run_in;

   // ---------------------------------------------------------------- csr
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      row_width_in = row_width_ff;
      if (csr_write && (csr_paddr[2] == llo_pkg::REG_ROW_WIDTH)) begin
         row_width_in = csr_pwdata[llo_pkg::ROW_WIDTH_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == llo_pkg::REG_ROW_WIDTH) begin
         csr_prdata = llo_pkg::CSR_DATA_W'(row_width_ff);
      end
   end

   // -------------------------------------------------------- input stage
   assign accept = req_valid && !req_stall;

   always_comb begin
      if (row_width_ff == '0) begin
         eff_width = WID_W'(1);
      end else if (32'(row_width_ff) > 32'(MAX_COLUMNS)) begin
         eff_width = WID_W'(MAX_COLUMNS);
      end else begin
         eff_width = WID_W'(row_width_ff);
      end
   end

   // A position at or past a narrowed width counts as the last column.
   assign last_col  = ({1'b0, col_ff} + WID_W'(1)) >= eff_width;
   assign anti_addr = col_ff + COL_W'(1);

   always_comb begin
      col_in       = col_ff;
      first_row_in = first_row_ff;
      if (accept) begin
         priority if (req_final_cell) begin
            col_in       = '0;
            first_row_in = 1'b1;
         end else if (last_col) begin
            col_in       = '0;
            first_row_in = 1'b0;
         end else begin
            col_in = anti_addr;
         end
      end
   end

   // ---------------------------------------------------------- run stage
   assign s1_advance = s1_valid_ff && !(s1_flags_ff.final_cell && rsp_valid_ff && rsp_stall);
   assign req_stall  = s1_valid_ff && !s1_advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
   end

   llo_line_buf #(.DEPTH(MAX_COLUMNS), .DATA_W(RUN_W), .ADDR_W(COL_W)) u_vert_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (vert_run),
      .rd_data (vert_rd)
   );

   llo_line_buf #(.DEPTH(MAX_COLUMNS), .DATA_W(RUN_W), .ADDR_W(COL_W)) u_diag_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (diag_run),
      .rd_data (diag_rd)
   );

   llo_line_buf #(.DEPTH(MAX_COLUMNS), .DATA_W(RUN_W), .ADDR_W(COL_W)) u_anti_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (anti_addr),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (anti_run),
      .rd_data (anti_rd)
   );

   // The diagonal value read for this column is the upper-left neighbor of
   // the next cell, so it is held for one cell.
   llo_runs #(.MAX_RUN(MAX_RUN), .RUN_W(RUN_W)) u_runs (
      .cell_set         (s1_cell_set_ff),
      .flags            (s1_flags_ff),
      .horiz_prev       (horiz_ff),
      .vert_above       (vert_rd),
      .diag_upper_left  (held_ul_ff),
      .anti_upper_right (anti_rd),
      .best_prev        (best_ff),
      .horiz_run        (horiz_run),
      .vert_run         (vert_run),
      .diag_run         (diag_run),
      .anti_run         (anti_run),
      .best_next        (best_next)
   );

   always_comb begin
      horiz_in   = horiz_ff;
      held_ul_in = held_ul_ff;
      best_in    = best_ff;
      if (s1_advance) begin
         if (s1_flags_ff.final_cell) begin
            horiz_in   = '0;
            held_ul_in = '0;
            best_in    = '0;
         end else begin
            horiz_in   = horiz_run;
            held_ul_in = diag_rd;
            best_in    = best_next;
         end
      end
   end

   // ---------------------------------------------------- result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_run_in   = rsp_run_ff;
      if (s1_advance && s1_flags_ff.final_cell) begin
         rsp_valid_in = 1'b1;
         rsp_run_in   = best_next;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_longest_run = rsp_run_ff;

   // ----------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= llo_pkg::ROW_WIDTH_RESET;
         col_ff       <= '0;
         first_row_ff <= 1'b1;
         s1_valid_ff  <= 1'b0;
         horiz_ff     <= '0;
         held_ul_ff   <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_width_ff <= row_width_in;
         col_ff       <= col_in;
         first_row_ff <= first_row_in;
         s1_valid_ff  <= s1_valid_in;
         horiz_ff     <= horiz_in;
         held_ul_ff   <= held_ul_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_run_ff <= rsp_run_in;
      if (accept) begin
         s1_cell_set_ff         <= req_cell_set;
         s1_col_ff              <= col_ff;
         s1_flags_ff.first_row  <= first_row_ff;
         s1_flags_ff.first_col  <= (col_ff == '0);
         s1_flags_ff.last_col   <= last_col;
         s1_flags_ff.final_cell <= req_final_cell;
      end
   end

endmodule

>>> hdl/llo_checker.sv
// ----------------------------------------------------------------------------
// llo_checker
// Port-level checks on the longest line of ones block, bound to its top.
// ----------------------------------------------------------------------------
module llo_checker #(
   parameter int MAX_RUN = llo_pkg::DEF_MAX_RUN,
   parameter int RUN_W   = $clog2(MAX_RUN + 1)
) (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             req_final_cell,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [RUN_W-1:0] rsp_longest_run,
   input logic             csr_pready
);

   // A waiting result beat holds until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_longest_run))
      else $error("result beat changed while stalled");

   // A new result comes only from a final cell that was taken earlier.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_final_cell, 2))
      else $error("result without a matching final cell");

   // No line is longer than the saturation limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_longest_run <= RUN_W'(MAX_RUN))
      else $error("longest run above saturation limit");

   // Reset drops any pending result.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result still valid after reset");

   // The configuration port never inserts wait states.
   assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("configuration port not ready");

endmodule

bind longest_line_of_ones_four_dir llo_checker #(
   .MAX_RUN (MAX_RUN),
   .RUN_W   (RUN_W)
) u_llo_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_final_cell  (req_final_cell),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_longest_run (rsp_longest_run),
   .csr_pready      (csr_pready)
);

>>> test/longest_line_of_ones_four_dir_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_line_of_ones_four_dir_checker
// Watches the cell, result and register ports of the longest-line block,
// keeps its own line buffers and run counters, and predicts the longest run
// of every matrix. Each result beat is compared with the oldest prediction,
// and every row_width read is compared with the last value written or reset.
// ----------------------------------------------------------------------------
module longest_line_of_ones_four_dir_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic                           req_cell_set,
   input  logic                           req_final_cell,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [10:0]                    rsp_longest_run,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [llo_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [llo_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [llo_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic                           csr_pready,
   output int                             mismatch_count,
   output int                             runs_pending,
   output int                             matrices_checked
);

   localparam int MAX_COLUMNS = llo_pkg::DEF_MAX_COLUMNS;
   localparam int MAX_RUN     = llo_pkg::DEF_MAX_RUN;
   localparam int RUN_W       = $clog2(MAX_RUN + 1);

   typedef bit [RUN_W-1:0] run_count_type;

   logic [llo_pkg::ROW_WIDTH_W-1:0] width_setting;
   run_count_type across_run;
   run_count_type held_upper_left;
   run_count_type down_runs [MAX_COLUMNS];
   run_count_type fall_runs [MAX_COLUMNS];
   run_count_type rise_runs [MAX_COLUMNS];
   int unsigned column_at;
   bit top_row;
   run_count_type best_run;
   run_count_type longest_runs_due [$];
   int failures = 0;
   int checked = 0;
   int pending_q = 0;

   assign mismatch_count   = failures;
   assign matrices_checked = checked;
   assign runs_pending     = pending_q;

   function automatic run_count_type extend(input run_count_type run);
      return (run >= MAX_RUN) ? run_count_type'(MAX_RUN) : run + 1'b1;
   endfunction

   function automatic void start_matrix();
      across_run      = '0;
      held_upper_left = '0;
      column_at       = 0;
      top_row         = 1'b1;
      best_run        = '0;
   endfunction

   function automatic void take_cell(input logic marked, input logic last_one);
      int unsigned span;
      int unsigned col;
      bit edge_col;
      run_count_type from_upper_left;
      run_count_type h, v, d, a;
      if (width_setting == 0) span = 1;
      else if (width_setting > MAX_COLUMNS) span = MAX_COLUMNS;
      else span = int'(width_setting);
      col = column_at;
      // A column at or past a freshly shrunk width still closes the row.
      edge_col = (col + 1 >= span);
      from_upper_left = held_upper_left;
      held_upper_left = fall_runs[col];
      if (marked) begin
         h = (col == 0) ? run_count_type'(1) : extend(across_run);
         v = top_row ? run_count_type'(1) : extend(down_runs[col]);
         d = (top_row || col == 0) ? run_count_type'(1) : extend(from_upper_left);
         if (top_row || edge_col) a = run_count_type'(1);
         else a = extend(rise_runs[col + 1]);
         if (h > best_run) best_run = h;
         if (v > best_run) best_run = v;
         if (d > best_run) best_run = d;
         if (a > best_run) best_run = a;
      end else begin
         h = '0;
         v = '0;
         d = '0;
         a = '0;
      end
      across_run     = h;
      down_runs[col] = v;
      fall_runs[col] = d;
      rise_runs[col] = a;
      if (edge_col) begin
         column_at = 0;
         top_row   = 1'b0;
      end else begin
         column_at = col + 1;
      end
      if (last_one) begin
         longest_runs_due.push_back(best_run);
         start_matrix();
      end
   endfunction

   always @(posedge clock) begin
      run_count_type due;
      if (reset) begin
         width_setting = llo_pkg::ROW_WIDTH_RESET;
         start_matrix();
         longest_runs_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready &&
             csr_paddr[2] == llo_pkg::REG_ROW_WIDTH) begin
            if (csr_pwrite) begin
               width_setting = csr_pwdata[llo_pkg::ROW_WIDTH_W-1:0];
            end else if (csr_prdata !== llo_pkg::CSR_DATA_W'(width_setting)) begin
               if (failures < 10)
                  $display("row_width readback: expected %0d, got %0d",
                           width_setting, csr_prdata);
               failures++;
            end
         end
         if (req_valid && !req_stall) take_cell(req_cell_set, req_final_cell);
         if (rsp_valid && !rsp_stall) begin
            if (longest_runs_due.size() == 0) begin
               if (failures < 10)
                  $display("result beat %0d arrived with no matrix outstanding",
                           rsp_longest_run);
               failures++;
            end else begin
               due = longest_runs_due.pop_front();
               checked++;
               if (rsp_longest_run !== due) begin
                  if (failures < 10)
                     $display("longest run mismatch in matrix %0d: expected %0d, got %0d",
                              checked, due, rsp_longest_run);
                  failures++;
               end
            end
         end
      end
      pending_q <= longest_runs_due.size();
   end

endmodule

>>> test/longest_line_of_ones_four_dir_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_line_of_ones_four_dir_test
// Streams binary matrices into the longest-line block under several row
// widths and idling patterns: a short directed set for the edge cases, a long
// single column for run saturation, then random matrices.
// ----------------------------------------------------------------------------
module longest_line_of_ones_four_dir_test;

   localparam int RUN_W       = $clog2(llo_pkg::DEF_MAX_RUN + 1);
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 4;
   localparam logic [llo_pkg::CSR_ADDR_W-1:0] ROW_WIDTH_ADDR =
      {llo_pkg::REG_ROW_WIDTH, 2'b00};
   localparam logic [llo_pkg::CSR_ADDR_W-1:0] UNUSED_REG_ADDR =
      {~llo_pkg::REG_ROW_WIDTH, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_cell_set = 1'b0;
   logic req_final_cell = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [RUN_W-1:0] rsp_longest_run;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [llo_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [llo_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [llo_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   int mismatch_count;
   int runs_pending;
   int matrices_checked;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int cells_sent = 0;
   int width_settings = 0;
   int cycles = 0;

   longest_line_of_ones_four_dir dut (.*);

   longest_line_of_ones_four_dir_checker checker_inst (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(1, 100) <= receiver_stall_pct);
   end

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Called right after a rising edge; returns at the edge that takes the beat.
   task automatic send_cell(input logic marked, input logic last_one);
      while ($urandom_range(1, 100) <= sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cell_set   <= marked;
      req_final_cell <= last_one;
      do @(posedge clock); while (req_stall);
      cells_sent++;
   endtask

   task automatic send_pattern(input logic [63:0] cells, input int count,
                               input bit closes_matrix);
      for (int i = 0; i < count; i++)
         send_cell(cells[i], closes_matrix && i == count - 1);
   endtask

   task automatic csr_access(input logic write, input logic [2:0] addr,
                             input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Upper data bits are random; only the low field should land.
   task automatic set_row_width(input logic [llo_pkg::ROW_WIDTH_W-1:0] width);
      csr_access(1'b1, ROW_WIDTH_ADDR, {21'($urandom), width});
      csr_access(1'b0, ROW_WIDTH_ADDR, '0);
      width_settings++;
   endtask

   // Lets every outstanding result drain and the pipeline go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (runs_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
         1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
         2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
         default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
   endtask

   initial begin
      int n;
      int rows;
      int pct;
      int span;
      int phase_cells;
      logic [llo_pkg::ROW_WIDTH_W-1:0] width;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset width, then one-cell matrices back to back.
      csr_access(1'b0, ROW_WIDTH_ADDR, '0);
      send_pattern(64'b0, 1, 1'b1);
      send_pattern(64'b1, 1, 1'b1);
      settle();

      // A write past the register list must leave row_width alone.
      set_row_width(11'd3);
      csr_access(1'b1, UNUSED_REG_ADDR, 32'h0000_0007);
      csr_access(1'b0, ROW_WIDTH_ADDR, '0);
      send_pattern(64'h054, 9, 1'b1);
      send_pattern(64'h111, 9, 1'b1);
      settle();

      // Width zero behaves as a single column.
      set_row_width(11'd0);
      send_pattern(64'h7, 3, 1'b1);
      settle();

      // Shrink the width in the middle of a matrix, past the current column.
      set_row_width(11'd4);
      send_pattern(64'h3f, 6, 1'b0);
      settle();
      set_row_width(11'd2);
      send_pattern(64'h2d, 6, 1'b1);
      settle();

      // A single column long enough to saturate the vertical run.
      set_idling(3);
      set_row_width(11'd1);
      for (int i = 0; i < 1030; i++) send_cell(1'b1, i == 1029);
      settle();

      for (int phase = 0; phase < 8; phase++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: width = 11'($urandom_range(1, 6));
            4, 5: width = 11'($urandom_range(7, 16));
            6: width = 11'd1;
            7: width = 11'd0;
            8: width = 11'($urandom_range(1025, 2047));
            default: width = 11'($urandom_range(17, 64));
         endcase
         set_row_width(width);
         set_idling(phase % 4);
         if (width == 0) span = 1;
         else if (width > llo_pkg::DEF_MAX_COLUMNS) span = llo_pkg::DEF_MAX_COLUMNS;
         else span = int'(width);
         phase_cells = 0;
         while (phase_cells < 16) begin
            if ($urandom_range(0, 9) == 0) begin
               n = 1;
            end else if (span > 64) begin
               n = $urandom_range(1, 48);
            end else begin
               rows = $urandom_range(1, span <= 4 ? 8 : (span <= 16 ? 4 : 2));
               n = rows * span;
               // Some matrices end partway through a row.
               if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
            end
            case ($urandom_range(0, 3))
               0: pct = 50;
               1: pct = 75;
               2: pct = 90;
               default: pct = 100;
            endcase
            for (int i = 0; i < n; i++)
               send_cell($urandom_range(1, 100) <= pct, i == n - 1);
            phase_cells += n;
         end
         settle();
      end

      $display("Checked %0d matrices built from %0d cells over %0d row-width settings.",
               matrices_checked, cells_sent, width_settings);
      $display("Widths were drawn from 0 to 2047, with a mid-matrix shrink and runs up to %0d.",
               llo_pkg::DEF_MAX_RUN);
      if (mismatch_count == 0 && runs_pending == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> filelist.f
hdl/llo_pkg.sv
hdl/llo_line_buf.sv
hdl/llo_runs.sv
hdl/longest_line_of_ones_four_dir.sv
hdl/llo_checker.sv
test/longest_line_of_ones_four_dir_checker.sv
test/longest_line_of_ones_four_dir_test.sv
